// ----- rtl/vn_pkg.sv -----
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types, sizes and helpers for the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int VEC_MAX   = 8;
  localparam int ELEM_BITS = 16;
  localparam int CNT_W     = $clog2(VEC_MAX + 1);
  localparam int IDX_W     = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
  localparam int SUM_W     = 2 * ELEM_BITS + $clog2(VEC_MAX) + 1;
  localparam int NORM_W    = 17;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int SQ_STEPS  = ELEM_BITS;
  localparam int RT_STEPS  = ROOT_W;
  localparam int DV_STEPS  = ELEM_BITS;

  typedef struct packed {
    logic signed [15:0] element;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] unit_component;
    logic [16:0]        vector_norm;
    logic               zero_norm;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clear;
  } sq_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DIVIDE,
    ST_PUSH
  } vn_state_t;

  function automatic logic [ELEM_BITS-1:0] mag_of(input logic signed [ELEM_BITS-1:0] v);
    logic signed [ELEM_BITS-1:0] n;
    n = -v;
    return v[ELEM_BITS-1] ? ELEM_BITS'(n) : ELEM_BITS'(v);
  endfunction

  // quotient never exceeds one full scale step, so only the positive side clips
  function automatic logic [ELEM_BITS-1:0] unit_sat(input logic [ELEM_BITS-1:0] q,
                                                    input logic neg);
    logic [ELEM_BITS-1:0] n;
    n = ~q + ELEM_BITS'(1);
    if (neg) begin
      return n;
    end
    return q[ELEM_BITS-1] ? {1'b0, {(ELEM_BITS-1){1'b1}}} : q;
  endfunction

endpackage

// ----- rtl/vn_square.sv -----
// ----------------------------------------------------------------------------
// vn_square
// Bit-serial squarer feeding the running sum of squares.
// ----------------------------------------------------------------------------
module vn_square
  import vn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sq_ctrl_t             ctrl,
  input  logic [ELEM_BITS-1:0] mag,
  output logic                 done,
  output logic [SUM_W-1:0]     sum
);

  localparam int CW = $clog2(SQ_STEPS);

  logic                   busy_r;
  logic                   done_r;
  logic [CW-1:0]          cnt_r;
  logic [2*ELEM_BITS-1:0] mcand_r;
  logic [ELEM_BITS-1:0]   mplier_r;
  logic [SUM_W-1:0]       sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(SQ_STEPS - 1));
      if (ctrl.clear) begin
        sum_r <= '0;
      end
      if (ctrl.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        mcand_r  <= (2*ELEM_BITS)'(mag);
        mplier_r <= mag;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          sum_r <= sum_r + SUM_W'(mcand_r);
        end
        mcand_r  <= {mcand_r[2*ELEM_BITS-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[ELEM_BITS-1:1]};
        cnt_r    <= cnt_r + CW'(1);
        if (cnt_r == CW'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

// ----- rtl/vn_sqrt.sv -----
// ----------------------------------------------------------------------------
// vn_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vn_sqrt
  import vn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [NORM_W-1:0] root
);

  localparam int CW  = $clog2(RT_STEPS);
  localparam int REM_W = NORM_W + 1;

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [SUM_W-1:0]  x_r;
  logic [REM_W-1:0]  rem_r;
  logic [NORM_W-1:0] root_r;
  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    trial;
  logic              ge;
  logic [REM_W:0]    rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], x_r[SUM_W-1 -: 2]};
    trial   = {root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      root_r <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(RT_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r    <= {x_r[SUM_W-3:0], 2'b00};
        rem_r  <= rem_nxt[REM_W-1:0];
        root_r <= {root_r[NORM_W-2:0], ge};
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == CW'(RT_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/vn_div.sv -----
// ----------------------------------------------------------------------------
// vn_div
// Restoring divider, one quotient bit per cycle, for magnitude * 2^15 / norm.
// ----------------------------------------------------------------------------
module vn_div
  import vn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ELEM_BITS-1:0] mag,
  input  logic [NORM_W-1:0]    divisor,
  output logic                 done,
  output logic [ELEM_BITS-1:0] quot
);

  localparam int CW = $clog2(DV_STEPS);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [NORM_W-1:0]    dsr_r;
  logic [NORM_W-1:0]    rem_r;
  logic [ELEM_BITS-1:0] dnd_r;
  logic [ELEM_BITS-1:0] quot_r;
  logic [NORM_W:0]      rem_sh;
  logic                 ge;
  logic [NORM_W:0]      rem_nxt;

  // magnitude never exceeds the norm, so the upper dividend bits start below it
  always_comb begin
    rem_sh  = {rem_r, dnd_r[ELEM_BITS-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(DV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dsr_r  <= divisor;
        rem_r  <= NORM_W'(mag[ELEM_BITS-1:1]);
        dnd_r  <= {mag[0], {(ELEM_BITS-1){1'b0}}};
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt[NORM_W-1:0];
        dnd_r  <= {dnd_r[ELEM_BITS-2:0], 1'b0};
        quot_r <= {quot_r[ELEM_BITS-2:0], ge};
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == CW'(DV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- rtl/vector_normalize.sv -----
// ----------------------------------------------------------------------------
// vector_normalize
// Euclidean normalization of a fixed-point vector, bit-serial datapath.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_      in   in_valid/in_ready  in_item_t  (element, last_element)
//  out_     out  out_valid/out_ready out_item_t (unit_component, vector_norm,
//                                               zero_norm, last_result)
//
//  each item is squared by the 16-step serial squarer; closing a vector runs
//  the 18-step square root, then the 16-step divider once per result (no
//  division on zero norm)
//  synchronous active-low reset clears control state and the running sum
//  a stalled result holds in the output register; the next item is taken
//  while the final result of a vector still waits
// ----------------------------------------------------------------------------
module vector_normalize
  import vn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  vn_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 close_r;
  logic                 zero_r;
  logic [NORM_W-1:0]    norm_r;
  logic signed [15:0]   comp_r [VEC_MAX];
  logic                 out_valid_r;
  out_item_t            out_data_r;

  sq_ctrl_t             sq_ctrl;
  logic                 sq_done;
  logic [SUM_W-1:0]     sq_sum;
  logic                 rt_start, rt_done;
  logic [NORM_W-1:0]    rt_root;
  logic                 dv_start, dv_done;
  logic [ELEM_BITS-1:0] dv_quot;
  logic                 out_load;
  logic                 idx_last;
  logic [CNT_W-1:0]     count_inc;

  assign count_inc = count_r + CNT_W'(1);
  assign idx_last  = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  vn_square u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (sq_ctrl),
    .mag   (mag_of(in_data.element)),
    .done  (sq_done),
    .sum   (sq_sum)
  );

  vn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (sq_sum),
    .done     (rt_done),
    .root     (rt_root)
  );

  vn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dv_start),
    .mag     (mag_of(comp_r[idx_nxt])),
    .divisor (rt_root),
    .done    (dv_done),
    .quot    (dv_quot)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    sq_ctrl   = '0;
    rt_start  = 1'b0;
    dv_start  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sq_ctrl.start = 1'b1;
          state_nxt     = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_done) begin
          if (close_r) begin
            rt_start      = 1'b1;
            sq_ctrl.clear = 1'b1;
            state_nxt     = ST_ROOT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ROOT: begin
        if (rt_done) begin
          idx_nxt = '0;
          if (rt_root == '0) begin
            state_nxt = ST_PUSH;
          end else begin
            dv_start  = 1'b1;
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (dv_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            if (!zero_r) begin
              dv_start  = 1'b1;
              state_nxt = ST_DIVIDE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      close_r     <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (in_valid && in_ready) begin
        count_r <= count_inc;
        close_r <= in_data.last_element || (count_inc == CNT_W'(VEC_MAX));
      end
      if (rt_done && state_r == ST_ROOT) begin
        zero_r <= (rt_root == '0);
      end
      if (out_load && idx_last) begin
        count_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      comp_r[count_r[IDX_W-1:0]] <= in_data.element;
    end
    if (rt_done && state_r == ST_ROOT) begin
      norm_r <= rt_root;
    end
    if (out_load) begin
      out_data_r.unit_component <= zero_r ? '0 : unit_sat(dv_quot, comp_r[idx_r][15]);
      out_data_r.vector_norm    <= norm_r;
      out_data_r.zero_norm      <= zero_r;
      out_data_r.last_result    <= idx_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/vn_checker.sv -----
// ----------------------------------------------------------------------------
// vn_checker
// Port-level checks on the vector normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module vn_checker
  import vn_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the squarer is busy right after an item is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while squaring");

  // zero flag matches the norm and clears the component
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.zero_norm == (out_data.vector_norm == '0)) &&
                  (!out_data.zero_norm || out_data.unit_component == '0))
    else $error("zero norm flag inconsistent");

  // no new item while results of a vector are still pending
  a_mid_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> !in_ready)
    else $error("input ready in the middle of a vector");

endmodule

bind vector_normalize vn_checker u_vn_checker (.*);
